[sv/sgrcpd_pkg.sv]
// Shared types, constants and color functions of the SGR color parameter decoder.
`default_nettype none

package sgrcpd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_VERSION,
    PH_IDX256,
    PH_RED,
    PH_GREEN,
    PH_BLUE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_FORE,
    TGT_BACK,
    TGT_BOTH
  } target_t;

  typedef enum logic [1:0] {
    OC_PEND,
    OC_RGB,
    OC_DEF,
    OC_KEEP
  } outcome_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ERR_CONT,
    ST_ERR_STOP
  } status_t;

  localparam logic [7:0] CODE_DEFAULT = 8'd0;
  localparam logic [7:0] CODE_FG_EXT  = 8'd38;
  localparam logic [7:0] CODE_BG_EXT  = 8'd48;
  localparam logic [7:0] CODE_FG_LO   = 8'd30;
  localparam logic [7:0] CODE_BG_LO   = 8'd40;
  localparam logic [7:0] CODE_FGB_LO  = 8'd90;
  localparam logic [7:0] CODE_BGB_LO  = 8'd100;
  localparam logic [7:0] VER_IDX256   = 8'd5;
  localparam logic [7:0] VER_RGB      = 8'd2;
  localparam logic [7:0] GRAY_START   = 8'd232;
  localparam logic [7:0] CUBE_START   = 8'd16;
  localparam logic [7:0] BRIGHT_START = 8'd8;
  localparam logic [7:0] CUBE_PLANE   = 8'd36;
  localparam logic [7:0] CUBE_ROW     = 8'd6;
  localparam logic [7:0] GRAY_STEP    = 8'd10;
  localparam logic [7:0] GRAY_BASE    = 8'd8;

  localparam logic [23:0] NORMAL_PAL [8] = '{
    24'h010101, 24'hDE382B, 24'h39B54A, 24'hFFC706,
    24'h006FB8, 24'h762671, 24'h2CB5E9, 24'hCCCCCC
  };

  localparam logic [23:0] BRIGHT_PAL [8] = '{
    24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  localparam logic [7:0] CUBE_LEVEL [6] = '{
    8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
  };

  typedef struct packed {
    logic [7:0] param_value;
    logic       param_empty;
    logic       param_malformed;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    target_t     target;
    logic [23:0] rgb;
    logic        triple_valid;
  } state_t;

  typedef struct packed {
    status_t    status;
    logic       finished;
    outcome_t   outcome;
    target_t    position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

  // Splits a cube offset (0 to 215) into its three level digits by compares and subtraction.
  function automatic logic [23:0] cube_rgb(input logic [7:0] c);
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
    logic [7:0] rem;
    r = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (c >= 8'(k * 36)) begin
        r = 3'(k);
      end
    end
    rem = c - 8'(8'(r) * CUBE_PLANE);
    g = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (rem >= 8'(k * 6)) begin
        g = 3'(k);
      end
    end
    b = 3'(rem - 8'(8'(g) * CUBE_ROW));
    return {CUBE_LEVEL[r], CUBE_LEVEL[g], CUBE_LEVEL[b]};
  endfunction

  // Resolves an xterm 256-color index to RGB.
  function automatic logic [23:0] idx256_rgb(input logic [7:0] v);
    logic [7:0] gray;
    gray = 8'(8'(v - GRAY_START) * GRAY_STEP) + GRAY_BASE;
    if (v < BRIGHT_START) begin
      return NORMAL_PAL[v[2:0]];
    end else if (v < CUBE_START) begin
      return BRIGHT_PAL[v[2:0]];
    end else if (v >= GRAY_START) begin
      return {gray, gray, gray};
    end else begin
      return cube_rgb(v - CUBE_START);
    end
  endfunction

endpackage

`default_nettype wire

[sv/sgrcpd_ifs.sv]
// Request and result channel interfaces of the SGR color parameter decoder.
`default_nettype none

interface sgrcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] param_value;
  logic       param_empty;
  logic       param_malformed;

  modport source (output valid, param_value, param_empty, param_malformed, input ready);
  modport sink (input valid, param_value, param_empty, param_malformed, output ready);
endinterface

interface sgrcpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       finished;
  logic [1:0] outcome;
  logic [1:0] position;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, status, finished, outcome, position, red, green, blue,
                  input ready);
  modport sink (input valid, status, finished, outcome, position, red, green, blue,
                output ready);
endinterface

`default_nettype wire

[sv/sgrcpd_step.sv]
// Next-state and result logic for one SGR parameter.
`default_nettype none

module sgrcpd_step
  import sgrcpd_pkg::*;
(
  input  state_t cur,
  input  item_t  item,
  output state_t nxt,
  output res_t   res
);

  logic [7:0] v;
  logic       empty;
  logic       bad;
  logic       last;
  logic       tv;
  status_t    st;
  logic       fin;
  outcome_t   oc;

  assign v     = item.param_value;
  assign empty = item.param_empty;
  assign bad   = item.param_malformed;
  assign last  = (cur.phase == PH_BLUE);
  assign tv    = cur.triple_valid & ~empty;

  always_comb begin
    nxt = cur;
    st  = ST_OK;
    fin = 1'b0;
    oc  = OC_PEND;
    unique case (cur.phase) inside
      PH_VERSION: begin
        nxt.phase = PH_DONE;
        if (empty) begin
          st = ST_ERR_CONT; fin = 1'b1; oc = OC_KEEP;
        end else if (bad) begin
          st = ST_ERR_STOP; fin = 1'b1; oc = OC_KEEP;
        end else if (v == VER_IDX256) begin
          nxt.phase = PH_IDX256;
        end else if (v == VER_RGB) begin
          nxt.phase = PH_RED;
        end else begin
          st = ST_ERR_CONT; fin = 1'b1; oc = OC_KEEP;
        end
      end
      PH_IDX256: begin
        nxt.phase = PH_DONE;
        fin = 1'b1;
        if (empty) begin
          st = ST_ERR_CONT; oc = OC_KEEP;
        end else if (bad) begin
          st = ST_ERR_STOP; oc = OC_KEEP;
        end else begin
          nxt.rgb = idx256_rgb(v);
          oc = OC_RGB;
        end
      end
      PH_RED, PH_GREEN, PH_BLUE: begin
        nxt.triple_valid = tv;
        if (cur.phase == PH_RED) begin
          nxt.phase = PH_GREEN;
        end else if (cur.phase == PH_GREEN) begin
          nxt.phase = PH_BLUE;
        end else begin
          nxt.phase = PH_DONE;
        end
        if (!tv) begin
          st  = ST_ERR_CONT;
          fin = last;
          oc  = last ? OC_KEEP : OC_PEND;
        end else if (bad) begin
          nxt.phase = PH_DONE;
          st = ST_ERR_STOP; fin = 1'b1; oc = OC_KEEP;
        end else begin
          if (cur.phase == PH_RED) begin
            nxt.rgb[23:16] = v;
          end else if (cur.phase == PH_GREEN) begin
            nxt.rgb[15:8] = v;
          end else begin
            nxt.rgb[7:0] = v;
          end
          fin = last;
          oc  = last ? OC_RGB : OC_PEND;
        end
      end
      default: begin
        nxt.rgb          = 24'd0;
        nxt.triple_valid = 1'b1;
        fin              = 1'b1;
        nxt.phase        = PH_DONE;
        if (empty || (!bad && v == CODE_DEFAULT)) begin
          nxt.target = TGT_BOTH;
          oc = OC_DEF;
        end else if (bad) begin
          nxt.target = TGT_NONE;
          st = ST_ERR_STOP; oc = OC_KEEP;
        end else if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
          nxt.target = (v == CODE_FG_EXT) ? TGT_FORE : TGT_BACK;
          nxt.phase  = PH_VERSION;
          fin = 1'b0;
        end else if (v >= CODE_FG_LO && v < CODE_FG_LO + 8'd8) begin
          nxt.target = TGT_FORE;
          nxt.rgb = NORMAL_PAL[3'(v - CODE_FG_LO)];
          oc = OC_RGB;
        end else if (v >= CODE_BG_LO && v < CODE_BG_LO + 8'd8) begin
          nxt.target = TGT_BACK;
          nxt.rgb = NORMAL_PAL[3'(v - CODE_BG_LO)];
          oc = OC_RGB;
        end else if (v >= CODE_FGB_LO && v < CODE_FGB_LO + 8'd8) begin
          nxt.target = TGT_FORE;
          nxt.rgb = BRIGHT_PAL[3'(v - CODE_FGB_LO)];
          oc = OC_RGB;
        end else if (v >= CODE_BGB_LO && v < CODE_BGB_LO + 8'd8) begin
          nxt.target = TGT_BACK;
          nxt.rgb = BRIGHT_PAL[3'(v - CODE_BGB_LO)];
          oc = OC_RGB;
        end else begin
          nxt.target = TGT_NONE;
          nxt.phase  = PH_FIRST;
          st = ST_ERR_CONT; fin = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    res.status   = st;
    res.finished = fin;
    res.outcome  = oc;
    res.position = nxt.target;
    res.red      = (oc == OC_RGB) ? nxt.rgb[23:16] : 8'd0;
    res.green    = (oc == OC_RGB) ? nxt.rgb[15:8]  : 8'd0;
    res.blue     = (oc == OC_RGB) ? nxt.rgb[7:0]   : 8'd0;
  end

endmodule

`default_nettype wire

[sv/sgr_color_parameter_decoder_unit.sv]
// Top level of the SGR color parameter decoder: input register, decode step, result register.
//
//   channel | direction | contents
//   in_bus  | sink      | param_value, param_empty, param_malformed
//   out_bus | source    | status, finished, outcome, position, red, green, blue
//
// Unless the result stalls, one request is taken per cycle and passes both registers in turn.
// The decode state advances when a request moves from the input register to the result register.
// Reset is synchronous and returns the parser to waiting for a first parameter.
// While the result is stalled, the input register still takes one more request.
`default_nettype none

module sgr_color_parameter_decoder_unit
  import sgrcpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  sgrcpd_in_if.sink    in_bus,
  sgrcpd_out_if.source out_bus
);

  logic   s1_vld_r;
  item_t  s1_item_r;
  state_t state_r;
  state_t state_nxt;
  res_t   res_nxt;
  logic   out_vld_r;
  res_t   out_res_r;
  logic   advance;
  logic   in_take;

  assign advance      = s1_vld_r & (~out_vld_r | out_bus.ready);
  assign in_bus.ready = rst_n & (~s1_vld_r | advance);
  assign in_take      = in_bus.valid & in_bus.ready;

  sgrcpd_step u_step (
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r               <= 1'b0;
      out_vld_r              <= 1'b0;
      state_r.phase          <= PH_FIRST;
      state_r.target         <= TGT_NONE;
      state_r.rgb            <= 24'd0;
      state_r.triple_valid   <= 1'b1;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.param_value     <= in_bus.param_value;
      s1_item_r.param_empty     <= in_bus.param_empty;
      s1_item_r.param_malformed <= in_bus.param_malformed;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_bus.valid    = out_vld_r;
  assign out_bus.status   = out_res_r.status;
  assign out_bus.finished = out_res_r.finished;
  assign out_bus.outcome  = out_res_r.outcome;
  assign out_bus.position = out_res_r.position;
  assign out_bus.red      = out_res_r.red;
  assign out_bus.green    = out_res_r.green;
  assign out_bus.blue     = out_res_r.blue;

endmodule

`default_nettype wire

[sv/sgrcpd_checker.sv]
// Port-level assertions for the SGR color parameter decoder and their binding.
`default_nettype none

module sgrcpd_checker
  import sgrcpd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic       out_finished,
  input wire logic [1:0] out_outcome,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A new result follows a request that was accepted and then held in the input register.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

  // A resolved color is always a successful, finished selection.
  a_rgb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OC_RGB |-> out_status == ST_OK && out_finished)
    else $error("color result with error or not finished");

  // Color bytes are zero unless a color is resolved.
  a_rgb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OC_RGB |-> out_red == 8'd0 && out_green == 8'd0
      && out_blue == 8'd0)
    else $error("color bytes set without a resolved color");

endmodule

bind sgr_color_parameter_decoder_unit sgrcpd_checker u_sgrcpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_status   (out_bus.status),
  .out_finished (out_bus.finished),
  .out_outcome  (out_bus.outcome),
  .out_red      (out_bus.red),
  .out_green    (out_bus.green),
  .out_blue     (out_bus.blue)
);

`default_nettype wire

[sim/sgr_color_parameter_decoder_unit_tb.sv]
// Self-checking testbench for the SGR color parameter decoder with a scoreboard and random stalls.
import sgrcpd_pkg::*;

class sgr_color_tracker;
  phase_t      phase;
  target_t     target;
  logic [23:0] rgb;
  bit          triple_ok;
  res_t        expected_colors[$];
  int          mismatches;

  function new();
    phase      = PH_FIRST;
    target     = TGT_NONE;
    rgb        = 24'h000000;
    triple_ok  = 1'b1;
    mismatches = 0;
  endfunction

  function logic [23:0] normal_color(int idx);
    case (idx)
      0: return 24'h010101;
      1: return {8'd222, 8'd56, 8'd43};
      2: return {8'd57, 8'd181, 8'd74};
      3: return {8'd255, 8'd199, 8'd6};
      4: return {8'd0, 8'd111, 8'd184};
      5: return {8'd118, 8'd38, 8'd113};
      6: return {8'd44, 8'd181, 8'd233};
      default: return {8'd204, 8'd204, 8'd204};
    endcase
  endfunction

  function logic [23:0] bright_color(int idx);
    case (idx)
      0: return {8'd128, 8'd128, 8'd128};
      1: return 24'hFF0000;
      2: return 24'h00FF00;
      3: return 24'hFFFF00;
      4: return 24'h0000FF;
      5: return 24'hFF00FF;
      6: return 24'h00FFFF;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function logic [7:0] cube_step(int lvl);
    case (lvl)
      0: return 8'd0;
      1: return 8'd95;
      2: return 8'd135;
      3: return 8'd175;
      4: return 8'd215;
      default: return 8'd255;
    endcase
  endfunction

  function logic [23:0] xterm_color(int v);
    logic [7:0] g;
    int c;
    if (v < 8) begin
      return normal_color(v);
    end else if (v < 16) begin
      return bright_color(v - 8);
    end else if (v >= 232) begin
      g = 8'((v - 232) * 10 + 8);
      return {g, g, g};
    end
    c = v - 16;
    return {cube_step(c / 36), cube_step((c % 36) / 6), cube_step(c % 6)};
  endfunction

  function void first_code(item_t it, ref res_t r);
    int v;
    v = it.param_value;
    rgb = 24'h000000;
    triple_ok = 1'b1;
    if (it.param_empty || (!it.param_malformed && v == CODE_DEFAULT)) begin
      target = TGT_BOTH;
      phase = PH_DONE;
      r.finished = 1'b1;
      r.outcome = OC_DEF;
    end else if (it.param_malformed) begin
      target = TGT_NONE;
      phase = PH_DONE;
      r.status = ST_ERR_STOP;
      r.finished = 1'b1;
      r.outcome = OC_KEEP;
    end else if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
      target = (v == CODE_FG_EXT) ? TGT_FORE : TGT_BACK;
      phase = PH_VERSION;
    end else if ((v >= 30 && v <= 37) || (v >= 40 && v <= 47)) begin
      target = (v < 40) ? TGT_FORE : TGT_BACK;
      rgb = normal_color(v % 10);
      phase = PH_DONE;
      r.finished = 1'b1;
      r.outcome = OC_RGB;
    end else if ((v >= 90 && v <= 97) || (v >= 100 && v <= 107)) begin
      target = (v < 100) ? TGT_FORE : TGT_BACK;
      rgb = bright_color(v % 10);
      phase = PH_DONE;
      r.finished = 1'b1;
      r.outcome = OC_RGB;
    end else begin
      target = TGT_NONE;
      phase = PH_FIRST;
      r.status = ST_ERR_CONT;
    end
  endfunction

  function res_t decode_param(item_t it);
    res_t r;
    phase_t cur;
    bit last;
    cur = phase;
    last = (cur == PH_BLUE);
    r = '0;
    r.status = ST_OK;
    r.outcome = OC_PEND;
    case (cur)
      PH_VERSION, PH_IDX256: begin
        phase = PH_DONE;
        r.finished = 1'b1;
        r.outcome = OC_KEEP;
        if (it.param_empty) begin
          r.status = ST_ERR_CONT;
        end else if (it.param_malformed) begin
          r.status = ST_ERR_STOP;
        end else if (cur == PH_IDX256) begin
          rgb = xterm_color(it.param_value);
          r.outcome = OC_RGB;
        end else if (it.param_value == VER_IDX256 || it.param_value == VER_RGB) begin
          phase = (it.param_value == VER_IDX256) ? PH_IDX256 : PH_RED;
          r.finished = 1'b0;
          r.outcome = OC_PEND;
        end else begin
          r.status = ST_ERR_CONT;
        end
      end
      PH_RED, PH_GREEN, PH_BLUE: begin
        if (it.param_empty) begin
          triple_ok = 1'b0;
        end
        case (cur)
          PH_RED: phase = PH_GREEN;
          PH_GREEN: phase = PH_BLUE;
          default: phase = PH_DONE;
        endcase
        if (!triple_ok) begin
          r.status = ST_ERR_CONT;
          r.finished = last;
          r.outcome = last ? OC_KEEP : OC_PEND;
        end else if (it.param_malformed) begin
          phase = PH_DONE;
          r.status = ST_ERR_STOP;
          r.finished = 1'b1;
          r.outcome = OC_KEEP;
        end else begin
          case (cur)
            PH_RED: rgb[23:16] = it.param_value;
            PH_GREEN: rgb[15:8] = it.param_value;
            default: rgb[7:0] = it.param_value;
          endcase
          r.finished = last;
          r.outcome = last ? OC_RGB : OC_PEND;
        end
      end
      default: first_code(it, r);
    endcase
    r.position = target;
    {r.red, r.green, r.blue} = (r.outcome == OC_RGB) ? rgb : 24'h000000;
    return r;
  endfunction

  function void note_param(item_t it);
    expected_colors.push_back(decode_param(it));
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_color(res_t got);
    res_t want;
    if (expected_colors.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_colors.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("finished", want.finished, got.finished);
    compare_field("outcome", want.outcome, got.outcome);
    compare_field("position", want.position, got.position);
    compare_field("red", want.red, got.red);
    compare_field("green", want.green, got.green);
    compare_field("blue", want.blue, got.blue);
  endfunction

  function int waiting();
    return expected_colors.size();
  endfunction
endclass

module sgr_color_parameter_decoder_unit_tb;
  localparam int STALL_LIMIT = 1000;
  localparam int PARAM_COUNT = 1450;

  logic clk;
  logic rst_n;
  sgr_color_tracker tracker;
  int idle_cycles;
  int params_sent;
  int stall_left;
  bit tx_calm;
  bit rx_calm;

  sgrcpd_in_if in_bus();
  sgrcpd_out_if out_bus();

  sgr_color_parameter_decoder_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #4 clk = ~clk;

  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      rx_calm = !rx_calm;
    end
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      out_bus.ready <= 1'b0;
      stall_left = idle_span() - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    item_t it;
    res_t got;
    if (rst_n) begin
      idle_cycles++;
      if (in_bus.valid && in_bus.ready) begin
        it.param_value = in_bus.param_value;
        it.param_empty = in_bus.param_empty;
        it.param_malformed = in_bus.param_malformed;
        tracker.note_param(it);
        idle_cycles = 0;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.status = status_t'(out_bus.status);
        got.finished = out_bus.finished;
        got.outcome = outcome_t'(out_bus.outcome);
        got.position = target_t'(out_bus.position);
        got.red = out_bus.red;
        got.green = out_bus.green;
        got.blue = out_bus.blue;
        tracker.check_color(got);
        idle_cycles = 0;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_param(input logic [7:0] v, input bit e, input bit m);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) < 50) ? 0 : idle_span();
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.param_value <= v;
    in_bus.param_empty <= e;
    in_bus.param_malformed <= m;
    do @(posedge clk); while (!in_bus.ready);
    params_sent++;
    if ($urandom_range(0, 99) < 2) begin
      tx_calm = !tx_calm;
    end
  endtask

  task automatic send_noisy(input logic [7:0] v);
    send_param(v, $urandom_range(0, 99) < 3, $urandom_range(0, 99) < 3);
  endtask

  task automatic random_sequence();
    int kind;
    logic [7:0] ext;
    kind = $urandom_range(0, 99);
    ext = $urandom_range(0, 1) ? CODE_FG_EXT : CODE_BG_EXT;
    if (kind < 30) begin
      case ($urandom_range(0, 5))
        0: send_noisy(CODE_DEFAULT);
        1: send_noisy(CODE_FG_LO + 8'($urandom_range(0, 7)));
        2: send_noisy(CODE_BG_LO + 8'($urandom_range(0, 7)));
        3: send_noisy(CODE_FGB_LO + 8'($urandom_range(0, 7)));
        4: send_noisy(CODE_BGB_LO + 8'($urandom_range(0, 7)));
        default: send_param(8'($urandom), 1'b1, $urandom_range(0, 1));
      endcase
    end else if (kind < 55) begin
      send_noisy(ext);
      send_noisy(VER_IDX256);
      case ($urandom_range(0, 3))
        0: send_noisy(8'($urandom_range(0, 15)));
        1: send_noisy(8'($urandom_range(16, 231)));
        2: send_noisy(8'($urandom_range(232, 255)));
        default: send_noisy(8'($urandom));
      endcase
    end else if (kind < 80) begin
      send_noisy(ext);
      send_noisy(VER_RGB);
      repeat (3) send_noisy(8'($urandom));
    end else if (kind < 90) begin
      send_param(8'($urandom), $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 20);
    end else begin
      send_noisy(ext);
      send_param(8'($urandom_range(0, 7)), $urandom_range(0, 99) < 15,
                 $urandom_range(0, 99) < 15);
      repeat ($urandom_range(0, 2)) send_param(8'($urandom), $urandom_range(0, 1), 1'b0);
    end
  endtask

  initial begin
    tracker = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.param_value = 8'h00;
    in_bus.param_empty = 1'b0;
    in_bus.param_malformed = 1'b0;
    out_bus.ready = 1'b0;
    idle_cycles = 0;
    params_sent = 0;
    stall_left = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // An empty first parameter, code zero, a malformed one, both flags, then fixed color codes.
    send_param(8'h5A, 1'b1, 1'b0);
    send_param(CODE_DEFAULT, 1'b0, 1'b0);
    send_param(8'hFF, 1'b0, 1'b1);
    send_param(8'hA5, 1'b1, 1'b1);
    send_param(CODE_FG_LO + 8'd7, 1'b0, 1'b0);
    send_param(CODE_BGB_LO + 8'd7, 1'b0, 1'b0);
    send_param(8'd99, 1'b0, 1'b0);
    send_param(CODE_FG_EXT, 1'b0, 1'b0);
    send_param(VER_IDX256, 1'b0, 1'b0);
    send_param(8'd231, 1'b0, 1'b0);
    send_param(CODE_BG_EXT, 1'b0, 1'b0);
    send_param(VER_IDX256, 1'b0, 1'b0);
    send_param(8'd255, 1'b0, 1'b0);
    send_param(CODE_FG_EXT, 1'b0, 1'b0);
    send_param(VER_RGB, 1'b0, 1'b0);
    send_param(8'd255, 1'b0, 1'b0);
    send_param(8'd0, 1'b0, 1'b0);
    send_param(8'd128, 1'b0, 1'b0);
    // An empty red byte spoils the rest of the triple, then 38 meets an unknown version.
    send_param(CODE_BG_EXT, 1'b0, 1'b0);
    send_param(VER_RGB, 1'b0, 1'b0);
    send_param(8'd0, 1'b1, 1'b0);
    send_param(8'd7, 1'b0, 1'b0);
    send_param(8'd9, 1'b0, 1'b0);
    send_param(CODE_FG_EXT, 1'b0, 1'b0);
    send_param(8'd7, 1'b0, 1'b0);

    while (params_sent < PARAM_COUNT) begin
      random_sequence();
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (tracker.waiting() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
